/* hw/rtl/pic_pkg.sv */
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the permutation interval counter.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int COORD_W = 11;
    localparam int COUNT_W = 20;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic               last;
    } t_pic_in;

    typedef struct packed {
        logic [COUNT_W-1:0] interval_count;
        logic               bad_input;
    } t_pic_out;

endpackage

/* hw/rtl/pic_seen.sv */
// ----------------------------------------------------------------------------
// pic_seen
// Row and column occupancy memories; flags a repeated row or column in the
// cycle after the mark, and clears one entry per cycle during a sweep.
// ----------------------------------------------------------------------------
module pic_seen #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mark,
    input  logic [AW-1:0] i_row_addr,
    input  logic [AW-1:0] i_col_addr,
    input  logic          i_clr,
    input  logic [AW-1:0] i_clr_addr,
    output logic          o_dup
);

    logic row_seen [2**AW];
    logic col_seen [2**AW];
    logic r_row_old;
    logic r_col_old;
    logic r_mark_d;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            row_seen[i_clr_addr] <= 1'b0;
            col_seen[i_clr_addr] <= 1'b0;
        end else if (i_mark) begin
            r_row_old            <= row_seen[i_row_addr];
            r_col_old            <= col_seen[i_col_addr];
            row_seen[i_row_addr] <= 1'b1;
            col_seen[i_col_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_d <= 1'b0;
        end else begin
            r_mark_d <= i_mark & ~i_clr;
        end
    end

    assign o_dup = r_mark_d & (r_row_old | r_col_old);

endmodule

/* hw/rtl/pic_scan.sv */
// ----------------------------------------------------------------------------
// pic_scan
// Column store and window counting engine: one store read per cycle walks
// every window start and end, keeping a running max and min.
// ----------------------------------------------------------------------------
module pic_scan
    import pic_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [COORD_W-1:0] i_wr_data,
    input  logic               i_start,
    input  logic [AW-1:0]      i_last_idx,
    output logic               o_done,
    output logic [COUNT_W-1:0] o_total
);

    logic [COORD_W-1:0] column_store [2**AW];

    logic               r_run;
    logic [AW-1:0]      r_l;
    logic [AW-1:0]      r_r;
    logic [COORD_W-1:0] r_q;
    logic               r_p_valid;
    logic               r_p_first;
    logic               r_p_last;
    logic [AW-1:0]      r_p_span;
    logic [COORD_W-1:0] r_hi;
    logic [COORD_W-1:0] r_lo;
    logic [COUNT_W-1:0] r_total;
    logic               r_done;
    logic [COORD_W-1:0] n_hi;
    logic [COORD_W-1:0] n_lo;
    logic               hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            column_store[i_wr_addr] <= i_wr_data;
        end
        r_q <= column_store[r_r];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_p_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_valid <= r_run;
            r_done    <= r_p_valid & r_p_last;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_r == i_last_idx && r_l == i_last_idx) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_first <= (r_r == r_l);
        r_p_last  <= (r_r == i_last_idx) && (r_l == i_last_idx);
        r_p_span  <= r_r - r_l;
        if (i_start) begin
            r_l <= '0;
            r_r <= '0;
        end else if (r_run) begin
            if (r_r == i_last_idx) begin
                r_l <= r_l + 1'b1;
                r_r <= r_l + 1'b1;
            end else begin
                r_r <= r_r + 1'b1;
            end
        end
    end

    always_comb begin
        n_hi = r_p_first ? r_q : ((r_q > r_hi) ? r_q : r_hi);
        n_lo = r_p_first ? r_q : ((r_q < r_lo) ? r_q : r_lo);
        hit  = (32'(n_hi - n_lo) == 32'(r_p_span));
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_total <= '0;
        end else if (r_p_valid) begin
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_total <= r_total + COUNT_W'(hit);
        end
    end

    assign o_done  = r_done;
    assign o_total = r_total;

endmodule

/* hw/rtl/permutation_interval_counter_unit.sv */
// ----------------------------------------------------------------------------
// permutation_interval_counter_unit
// Loads (row, column) points into a column store, checks that they form a
// permutation, and counts the row windows whose column span matches.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while busy is low. After the point marked
// last, the S_SETTLE state checks the set; a bad set reports in the next
// cycle, and a good set is scanned with one column-store read per cycle.
// The single result appears on o_valid for one cycle and cannot be held
// off. Then, and also after reset, busy stays high for a sweep over all
// MAX_POINTS addresses that clears the row and column occupancy memories.
// ----------------------------------------------------------------------------
module permutation_interval_counter_unit
    import pic_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_pic_in  i_item,
    output logic     busy,
    output logic     o_valid,
    output t_pic_out o_result
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;

    logic [2:0]         r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [CNTW-1:0]    r_loaded;
    logic               r_err;
    logic [COORD_W-1:0] r_max_row;
    logic [COORD_W-1:0] r_max_col;
    logic               r_valid;
    t_pic_out           r_result;

    logic               accept;
    logic               full;
    logic               in_range;
    logic               store;
    logic               dup;
    logic               bad;
    logic               scan_start;
    logic               scan_done;
    logic [COUNT_W-1:0] scan_total;
    logic [AW-1:0]      row_addr;
    logic [AW-1:0]      col_addr;

    assign busy     = (r_state != S_LOAD);
    assign accept   = start & ~busy;
    assign full     = (32'(r_loaded) >= MAX_POINTS);
    assign in_range = (i_item.row != '0) && (32'(i_item.row) <= MAX_POINTS)
                   && (i_item.column != '0) && (32'(i_item.column) <= MAX_POINTS);
    assign store    = accept & ~full & in_range;
    assign row_addr = AW'(i_item.row - 1'b1);
    assign col_addr = AW'(i_item.column - 1'b1);
    assign bad      = r_err | dup | (32'(r_max_row) > 32'(r_loaded))
                   | (32'(r_max_col) > 32'(r_loaded));
    assign scan_start = (r_state == S_SETTLE) & ~bad;

    pic_seen #(.AW(AW)) u_seen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mark     (store),
        .i_row_addr (row_addr),
        .i_col_addr (col_addr),
        .i_clr      (r_state == S_CLEAR),
        .i_clr_addr (r_clr_addr),
        .o_dup      (dup)
    );

    pic_scan #(.AW(AW)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (store),
        .i_wr_addr  (row_addr),
        .i_wr_data  (i_item.column),
        .i_start    (scan_start),
        .i_last_idx (AW'(r_loaded - 1'b1)),
        .o_done     (scan_done),
        .o_total    (scan_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_loaded   <= '0;
            r_err      <= 1'b0;
            r_max_row  <= '0;
            r_max_col  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (32'(r_clr_addr) == MAX_POINTS - 1) begin
                        r_clr_addr <= '0;
                        r_loaded   <= '0;
                        r_err      <= 1'b0;
                        r_max_row  <= '0;
                        r_max_col  <= '0;
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (dup) begin
                        r_err <= 1'b1;
                    end
                    if (accept) begin
                        if (full || !in_range) begin
                            r_err <= 1'b1;
                        end
                        if (!full) begin
                            r_loaded <= r_loaded + 1'b1;
                        end
                        if (store) begin
                            if (i_item.row > r_max_row) begin
                                r_max_row <= i_item.row;
                            end
                            if (i_item.column > r_max_col) begin
                                r_max_col <= i_item.column;
                            end
                        end
                        if (i_item.last) begin
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_SETTLE: begin
                    if (bad) begin
                        r_valid                 <= 1'b1;
                        r_result.interval_count <= '0;
                        r_result.bad_input      <= 1'b1;
                        r_state                 <= S_CLEAR;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_valid                 <= 1'b1;
                        r_result.interval_count <= scan_total;
                        r_result.bad_input      <= 1'b0;
                        r_state                 <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* sim/pic_checker.sv */
// ----------------------------------------------------------------------------
// pic_checker
// Watches the point and result channels of the interval counter, keeps its
// own copy of the point set, and compares each result with the expected one.
// ----------------------------------------------------------------------------
module pic_checker
    import pic_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_pic_in  i_item,
    input  logic     i_valid,
    input  t_pic_out i_result,
    output int       o_errors,
    output int       o_pending
);

    logic [COORD_W-1:0] col_by_row [MAX_POINTS];
    bit                 row_used   [MAX_POINTS];
    bit                 col_used   [MAX_POINTS];
    int                 set_size;
    bit                 set_bad;
    t_pic_out           expected_results [$];

    assign o_pending = expected_results.size();

    function automatic int count_intervals(int n);
        int total;
        int hi;
        int lo;
        total = 0;
        for (int l = 0; l < n; l++) begin
            hi = col_by_row[l];
            lo = hi;
            for (int r = l; r < n; r++) begin
                if (col_by_row[r] > hi) hi = col_by_row[r];
                if (col_by_row[r] < lo) lo = col_by_row[r];
                if (hi - lo == r - l) total++;
            end
        end
        return total;
    endfunction

    task automatic clear_set();
        foreach (row_used[k]) begin
            row_used[k] = 0;
            col_used[k] = 0;
        end
        set_size = 0;
        set_bad  = 0;
    endtask

    task automatic absorb_point(t_pic_in p);
        t_pic_out exp_res;
        bit       bad;
        int       total;
        if (set_size >= MAX_POINTS) begin
            set_bad = 1;
        end else begin
            set_size++;
            if (p.row == 0 || p.row > MAX_POINTS || p.column == 0 || p.column > MAX_POINTS) begin
                set_bad = 1;
            end else begin
                if (row_used[p.row-1]) set_bad = 1;
                if (col_used[p.column-1]) set_bad = 1;
                row_used[p.row-1]   = 1;
                col_used[p.column-1] = 1;
                col_by_row[p.row-1] = p.column;
            end
        end
        if (p.last) begin
            bad = set_bad;
            for (int k = 0; k < set_size && !bad; k++) begin
                if (!row_used[k] || !col_used[k]) bad = 1;
            end
            total = bad ? 0 : count_intervals(set_size);
            exp_res.interval_count = total[COUNT_W-1:0];
            exp_res.bad_input      = bad;
            expected_results.push_back(exp_res);
            clear_set();
        end
    endtask

    always @(posedge i_clk) begin
        t_pic_out exp_res;
        if (!i_rst_n) begin
            clear_set();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_start && !i_busy) absorb_point(i_item);
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result count=%0d bad=%0b", $time,
                             i_result.interval_count, i_result.bad_input);
                    o_errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_result.interval_count !== exp_res.interval_count) begin
                        $display("%0t: interval_count expected %0d actual %0d", $time,
                                 exp_res.interval_count, i_result.interval_count);
                        o_errors++;
                    end
                    if (i_result.bad_input !== exp_res.bad_input) begin
                        $display("%0t: bad_input expected %0b actual %0b", $time,
                                 exp_res.bad_input, i_result.bad_input);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives point sets into the interval counter: directed extremes and error
// cases, then mostly random permutations with some broken sets.
// ----------------------------------------------------------------------------
module tb_top;
    import pic_pkg::*;

    localparam int MAXP = 1024;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_pic_in  i_item;
    logic     busy;
    logic     o_valid;
    t_pic_out o_result;
    int       errors;
    int       pending;
    bit       idle_on;

    permutation_interval_counter_unit #(.MAX_POINTS(MAXP)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    pic_checker #(.MAX_POINTS(MAXP)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_item   (i_item),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // one point transfer; returns at the edge that took it
    task automatic push_point(int row, int col, bit last);
        bit free;
        if (idle_on && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_item.row     <= row[COORD_W-1:0];
        i_item.column  <= col[COORD_W-1:0];
        i_item.last    <= last;
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
    endtask

    // mode 0: random order permutation, 1: identity, 2: one point altered (mostly broken)
    task automatic send_set(int n, int mode);
        int cols[];
        int rows[];
        int victim;
        cols = new[n];
        rows = new[n];
        for (int k = 0; k < n; k++) begin
            cols[k] = k + 1;
            rows[k] = k + 1;
        end
        if (mode != 1) begin
            cols.shuffle();
            rows.shuffle();
        end
        if (mode == 2) begin
            victim = $urandom_range(0, n - 1);
            case ($urandom_range(0, 4))
                0: rows[victim] = rows[(victim + 1) % n];
                1: cols[victim] = cols[(victim + 1) % n];
                2: rows[victim] = $urandom_range(0, 2047);
                3: cols[victim] = $urandom_range(0, 2047);
                default: rows[victim] = 0;
            endcase
        end
        for (int k = 0; k < n; k++) push_point(rows[k], cols[k], k == n - 1);
    endtask

    task automatic drain();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int n;
        int r;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        idle_on = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_point(1, 1, 1);
        push_point(1, 2, 0);
        push_point(2, 1, 1);
        push_point(2, 2, 0);
        push_point(1, 1, 1);
        push_point(0, 1, 1);
        push_point(1, 0, 1);
        push_point(2047, 2047, 1);
        push_point(1024, 1024, 1);
        push_point(1, 1, 0);
        push_point(1, 2, 1);
        push_point(1, 1, 0);
        push_point(2, 1, 1);
        push_point(3, 1, 0);
        push_point(1, 2, 1);
        send_set(MAXP, 1);
        drain();
        for (int k = 0; k <= MAXP; k++) push_point((k % MAXP) + 1, (k % MAXP) + 1, k == MAXP);
        drain();

        n = 0;
        while (n < 500) begin
            idle_on = !(n > 150 && n < 300);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_set($urandom_range(11, 40), 0);
            end else if (r < 15) begin
                send_set($urandom_range(1, 10), 2);
            end else if (r < 20) begin
                send_set($urandom_range(1, 10), 1);
            end else begin
                send_set($urandom_range(1, 10), 0);
            end
            n += 6;
            if ($urandom_range(0, 19) == 0) drain();
        end

        drain();
        repeat (1100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("permutation_interval_counter_unit test passed");
        end else begin
            $display("permutation_interval_counter_unit test failed");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("permutation_interval_counter_unit test failed");
        $finish;
    end

endmodule
